### rtl/wdt_pkg.sv
// Shared types and constants for the two-stage watchdog timer.
// No dependencies.
`default_nettype none

package wdt_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  localparam logic [31:0] KEY_VALUE   = 32'h1ACCE551;

  localparam logic [11:0] OFS_LOAD    = 12'h000;
  localparam logic [11:0] OFS_VALUE   = 12'h004;
  localparam logic [11:0] OFS_CTRL    = 12'h008;
  localparam logic [11:0] OFS_INTCLR  = 12'h00C;
  localparam logic [11:0] OFS_RIS     = 12'h010;
  localparam logic [11:0] OFS_MIS     = 12'h014;
  localparam logic [11:0] OFS_LOCK    = 12'hC00;
  localparam logic [11:0] OFS_ID_BASE = 12'hFE0;

  localparam int CTRL_IE_BIT = 0;
  localparam int CTRL_RE_BIT = 1;

  typedef struct packed {
    op_t         op;
    logic [11:0] ofs;
    logic [31:0] data;
  } wdt_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        reset_out;
  } wdt_rsp_t;

  // Peripheral/PrimeCell ID bytes, 0xFE0..0xFFC
  function automatic logic [7:0] id_word(input logic [2:0] idx);
    logic [7:0] w;
    case (idx)
      3'd0:    w = 8'h05;
      3'd1:    w = 8'h18;
      3'd2:    w = 8'h14;
      3'd3:    w = 8'h00;
      3'd4:    w = 8'h0D;
      3'd5:    w = 8'hF0;
      3'd6:    w = 8'h05;
      3'd7:    w = 8'hB1;
      default: w = 8'h00;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/wdt_core.sv
// Watchdog register file, down-counter and expiry logic.
// Depends on wdt_pkg. State commits only when adv is high.
`default_nettype none

module wdt_core
  import wdt_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     adv,
  input  wire wdt_req_t req,
  output wdt_rsp_t      rsp
);

  logic [COUNT_WIDTH-1:0] load_reg, load_reg_next;
  logic [COUNT_WIDTH-1:0] down_count, down_count_next;
  logic irq_en, irq_en_next;
  logic reset_en, reset_en_next;
  logic raw_int, raw_int_next;
  logic write_locked, write_locked_next;
  logic reset_req, reset_req_next;
  logic [31:0] rd;

  always_comb begin
    load_reg_next     = load_reg;
    down_count_next   = down_count;
    irq_en_next       = irq_en;
    reset_en_next     = reset_en;
    raw_int_next      = raw_int;
    write_locked_next = write_locked;
    reset_req_next    = reset_req;
    rd                = 32'd0;

    case (req.op)
      OP_TICK: begin
        if (irq_en && !reset_req) begin
          if (down_count != '0) begin
            down_count_next = down_count - COUNT_WIDTH'(1);
          end else if (raw_int && reset_en) begin
            // second expiry with no service
            reset_req_next = 1'b1;
          end else begin
            raw_int_next    = 1'b1;
            down_count_next = load_reg;
          end
        end
      end
      OP_READ: begin
        case (req.ofs)
          OFS_LOAD:  rd = 32'(load_reg);
          OFS_VALUE: rd = 32'(down_count);
          OFS_CTRL:  rd = {30'd0, reset_en, irq_en};
          OFS_RIS:   rd = {31'd0, raw_int};
          OFS_MIS:   rd = {31'd0, raw_int & irq_en};
          OFS_LOCK:  rd = {31'd0, write_locked};
          default: begin
            if (req.ofs >= OFS_ID_BASE && req.ofs[1:0] == 2'b00) begin
              rd = 32'(id_word(req.ofs[4:2]));
            end
          end
        endcase
      end
      OP_WRITE: begin
        if (req.ofs == OFS_LOCK) begin
          write_locked_next = (req.data != KEY_VALUE);
        end else if (!write_locked) begin
          case (req.ofs)
            OFS_LOAD: begin
              load_reg_next   = req.data[COUNT_WIDTH-1:0];
              down_count_next = req.data[COUNT_WIDTH-1:0];
            end
            OFS_CTRL: begin
              // enabling restarts the count from the load value
              if (req.data[CTRL_IE_BIT] && !irq_en) begin
                down_count_next = load_reg;
              end
              irq_en_next   = req.data[CTRL_IE_BIT];
              reset_en_next = req.data[CTRL_RE_BIT];
            end
            OFS_INTCLR: begin
              raw_int_next    = 1'b0;
              down_count_next = load_reg;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    rsp.read_data = rd;
    rsp.irq       = raw_int_next & irq_en_next;
    rsp.reset_out = reset_req_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_reg     <= '1;
      down_count   <= '1;
      irq_en       <= 1'b0;
      reset_en     <= 1'b0;
      raw_int      <= 1'b0;
      write_locked <= 1'b0;
      reset_req    <= 1'b0;
    end else if (adv) begin
      load_reg     <= load_reg_next;
      down_count   <= down_count_next;
      irq_en       <= irq_en_next;
      reset_en     <= reset_en_next;
      raw_int      <= raw_int_next;
      write_locked <= write_locked_next;
      reset_req    <= reset_req_next;
    end
  end

endmodule

`default_nettype wire

### rtl/watchdog_two_stage_timer.sv
// Two-stage watchdog timer top: input register, core, result register.
// Depends on wdt_pkg and wdt_core.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------
//   in      | in_valid/in_stall  | opcode, reg_offset, write_data
//   out     | out_valid/out_stall| read_data, irq, reset_out
//
// The result is captured in the result register once the item leaves the input
// register; one item per cycle sustained while out_stall is low. The core
// state update is combinational logic between the input and result registers.
// rst is synchronous: control state clears, load and count reset to all ones.
// out_stall holds the result register; in_stall rises only when the input
// register is full and cannot move on.
`default_nettype none

module watchdog_two_stage_timer
  import wdt_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [11:0] reg_offset,
  input  wire logic [31:0] write_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      read_data,
  output logic             irq,
  output logic             reset_out
);

  logic     s1_valid;
  wdt_req_t s1_req;
  wdt_rsp_t rsp;
  logic     out_ready;
  logic     adv;

  assign out_ready = !out_valid || !out_stall;
  assign adv       = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;

  wdt_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .req(s1_req),
    .rsp(rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_req <= '{op: op_t'(opcode), ofs: reg_offset, data: write_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
    if (adv) begin
      read_data <= rsp.read_data;
      irq       <= rsp.irq;
      reset_out <= rsp.reset_out;
    end
  end

`ifndef SYNTHESIS
  // reset request is sticky until rst
  a_reset_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && reset_out |=> !out_valid || reset_out)
    else $error("reset_out dropped without rst");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with room in the pipeline");

  a_progress: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_valid |=> out_valid)
    else $error("pending item did not reach result register");
`endif

endmodule

`default_nettype wire
